// ===== src/dpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dpq_pkg
// Shared types and constants for the double-ended priority queue unit.
// ----------------------------------------------------------------------------
package dpq_pkg;

	localparam int CAPACITY = 256;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_TAKE_HIGH = 2'd1,
		OP_TAKE_LOW  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_SERVED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic        [1:0]  operation;
		logic signed [31:0] client_id;
		logic signed [31:0] priority_req;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] served_client;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] prio;
		logic signed [31:0] client;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   shl;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

// ===== src/dpq_cell.sv =====
// ----------------------------------------------------------------------------
// dpq_cell
// One slot of the sorted entry chain: holds, takes the new entry, or takes a
// neighbor's entry.
// ----------------------------------------------------------------------------
module dpq_cell import dpq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      less_prev,
	input  entry_t    left,
	input  entry_t    right,
	output entry_t    entry,
	output logic      less
);

	entry_t entry_q;

	assign entry = entry_q;
	assign less  = occupied && ($signed(entry_q.prio) < $signed(ctl.new_entry.prio));

	always_ff @(posedge clk) begin
		priority if (ctl.ins) begin
			if (!less) begin
				entry_q <= less_prev ? ctl.new_entry : left;
			end
		end else if (ctl.shl) begin
			entry_q <= right;
		end else begin
			entry_q <= entry_q;
		end
	end

endmodule

// ===== src/double_ended_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Double-ended priority queue built as a sorted chain of entry cells.
// ----------------------------------------------------------------------------
// For each transaction, start is taken when busy is low, busy is
// high for the following cycle while the whole cell chain compares against the
// new priority and shifts in parallel, and any result is shown with done high
// for exactly one cycle after that; a new transaction may be started in that
// same cycle. An insert gives no result unless the queue is full. Ties rank
// below older entries of the same priority. The chain length (CAPACITY cells)
// sets the comparator fan-out and the depth of the top-entry select.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit import dpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	req_t             req_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             full;
	logic             empty;
	cell_ctl_t        ctl;
	rsp_t             rsp_d;
	logic             done_d;
	logic [CNT_W-1:0] count_d;
	logic signed [31:0] hi_client;

	entry_t cell_entry [CAPACITY];
	logic   cell_less  [CAPACITY];

	assign busy   = busy_q;
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign accept = start && !busy_q;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	always_comb begin
		ctl.ins              = busy_q && (req_q.operation == OP_INSERT) && !full;
		ctl.shl              = busy_q && (req_q.operation == OP_TAKE_LOW) && !empty;
		ctl.new_entry.prio   = req_q.priority_req;
		ctl.new_entry.client = req_q.client_id;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   lprev;
		entry_t lnb;
		entry_t rnb;
		if (i == 0) begin : g_first
			assign lprev = 1'b1;
			assign lnb   = ctl.new_entry;
		end else begin : g_mid
			assign lprev = cell_less[i-1];
			assign lnb   = cell_entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rnb = cell_entry[i];
		end else begin : g_inner
			assign rnb = cell_entry[i+1];
		end
		dpq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (count_q > CNT_W'(i)),
			.less_prev (lprev),
			.left      (lnb),
			.right     (rnb),
			.entry     (cell_entry[i]),
			.less      (cell_less[i])
		);
	end

	always_comb begin
		hi_client = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (count_q == CNT_W'(i + 1)) begin
				hi_client = hi_client | cell_entry[i].client;
			end
		end
	end

	always_comb begin
		done_d  = 1'b0;
		rsp_d   = '0;
		count_d = count_q;
		unique case (req_q.operation)
			OP_INSERT: begin
				if (full) begin
					done_d       = 1'b1;
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_TAKE_HIGH, OP_TAKE_LOW: begin
				done_d = 1'b1;
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					count_d             = count_q - CNT_W'(1);
					rsp_d.status        = ST_SERVED;
					rsp_d.served_client = (req_q.operation == OP_TAKE_HIGH) ?
						hi_client : cell_entry[0].client;
				end
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q  <= 1'b0;
				done_q  <= done_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (busy_q) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result without a transaction in progress");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted transaction not started");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (req_q.operation == OP_INSERT) && !full) |=> !done_q)
		else $error("result given for a stored insert");
`endif

endmodule
